>>> design/fhpd_pkg.sv
// Shared types, codes and constants for the FSK half-period byte demodulator.
package fhpd_pkg;

	localparam int CAPTURE_BITS_DEFAULT = 16;
	localparam int CAPTURE_TIME_W       = 16;
	localparam int CFG_W                = 16;
	localparam int CFG_INDEX_W          = 2;
	localparam int BYTE_W               = 8;
	localparam int BIT_INDEX_W          = 4;
	localparam int QUEUE_DEPTH          = 2;

	localparam logic [CFG_W-1:0] MODULUS_RESET     = 16'd50000;
	localparam logic [CFG_W-1:0] BIT_THR_RESET     = 16'd14000;
	localparam logic [CFG_W-1:0] START_THR_RESET   = 16'd17000;
	localparam logic [BIT_INDEX_W-1:0] PARITY_SLOT = 4'd8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODULUS   = 2'd0,
		REG_BIT_THR   = 2'd1,
		REG_START_THR = 2'd2
	} reg_index_t;

	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WAIT = 2'd1,
		MODE_READ = 2'd2,
		MODE_DONE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CFG_W-1:0] counter_modulus;
		logic [CFG_W-1:0] bit_threshold;
		logic [CFG_W-1:0] start_threshold;
	} cfg_t;

endpackage

>>> design/fhpd_front.sv
// Front end: accepts events and measures the half-period of each capture edge.
module fhpd_front import fhpd_pkg::*; #(
	parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      opcode,
	input  logic [CAPTURE_TIME_W-1:0] capture_time,
	input  logic                      q_full,
	output logic                      push,
	output logic                      push_op,
	output logic [((CAPTURE_BITS < CAPTURE_TIME_W + 1) ? CAPTURE_BITS
	                : CAPTURE_TIME_W + 1)-1:0] push_hp
);

	localparam int CAP_W = (CAPTURE_BITS < CAPTURE_TIME_W) ? CAPTURE_BITS : CAPTURE_TIME_W;
	localparam int HP_W  = (CAPTURE_BITS < CAPTURE_TIME_W + 1) ? CAPTURE_BITS
	                       : CAPTURE_TIME_W + 1;
	localparam int D_W   = CAPTURE_TIME_W + 1;

	logic [CAP_W-1:0] prev_q;
	logic [CAP_W-1:0] cur;
	logic [D_W-1:0]   diff;

	assign cur      = capture_time[CAP_W-1:0];
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign push_op  = opcode;

	always_comb begin
		if (cur >= prev_q) begin
			diff = D_W'(cur) - D_W'(prev_q);
		end else begin
			diff = D_W'(cfg.counter_modulus) + D_W'(cur) - D_W'(prev_q);
		end
	end

	assign push_hp = diff[HP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (push && opcode == OP_EDGE) begin
			prev_q <= cur;
		end
	end

endmodule

>>> design/fhpd_queue.sv
// Short word queue that decouples the front end from the frame sequencer.
module fhpd_queue import fhpd_pkg::*; #(
	parameter int WIDTH = 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("queue read while empty");

endmodule

>>> design/fhpd_back.sv
// Back end: frame sequencer that samples bits on timer ticks and emits bytes.
module fhpd_back import fhpd_pkg::*; #(
	parameter int HP_W = CAPTURE_TIME_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  logic              q_op,
	input  logic [HP_W-1:0]   q_hp,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] data_byte,
	output logic              parity_error
);

	localparam int CMP_W = CAPTURE_TIME_W + 1;

	mode_t                  mode_q, mode_d;
	logic                   wait_q, wait_d;
	logic [HP_W-1:0]        hp_q, hp_d;
	logic [BYTE_W-1:0]      shift_q, shift_d;
	logic [BIT_INDEX_W-1:0] idx_q, idx_d;
	logic                   par_q, par_d;
	logic                   timer_q, timer_d;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      data_q;
	logic                   perr_q;
	logic                   emit_req, out_free, emit, is_edge, is_tick, sample;

	assign is_edge  = (q_op == OP_EDGE);
	assign is_tick  = (q_op == OP_TICK);
	assign sample   = CMP_W'(hp_q) > CMP_W'(cfg.bit_threshold);

	always_comb begin
		emit_req = q_valid && is_tick && timer_q && mode_q == MODE_DONE;
		out_free = !out_valid_q || !out_stall;
		pop      = q_valid && (!emit_req || out_free);
		emit     = pop && emit_req;
	end

	always_comb begin
		mode_d  = mode_q;
		wait_d  = wait_q;
		hp_d    = hp_q;
		shift_d = shift_q;
		idx_d   = idx_q;
		par_d   = par_q;
		timer_d = timer_q;
		if (pop && is_edge) begin
			hp_d = q_hp;
			unique case (mode_q)
				MODE_IDLE: begin
					if (CMP_W'(q_hp) < CMP_W'(cfg.start_threshold)) begin
						mode_d = MODE_WAIT;
					end
				end
				MODE_WAIT: begin
					if (wait_q) begin
						mode_d  = MODE_READ;
						timer_d = 1'b1;
						wait_d  = 1'b0;
					end else begin
						wait_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (pop && is_tick && timer_q) begin
			unique case (mode_q)
				MODE_READ: begin
					if (idx_q >= PARITY_SLOT) begin
						par_d  = sample;
						idx_d  = '0;
						mode_d = MODE_DONE;
					end else begin
						shift_d[3'd7 - idx_q[2:0]] = shift_q[3'd7 - idx_q[2:0]] | sample;
						idx_d = idx_q + 1'b1;
					end
				end
				default: begin
					timer_d = 1'b0;
					mode_d  = MODE_IDLE;
					shift_d = '0;
					par_d   = 1'b0;
					idx_d   = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			wait_q  <= 1'b0;
			hp_q    <= '0;
			shift_q <= '0;
			idx_q   <= '0;
			par_q   <= 1'b0;
			timer_q <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			wait_q  <= wait_d;
			hp_q    <= hp_d;
			shift_q <= shift_d;
			idx_q   <= idx_d;
			par_q   <= par_d;
			timer_q <= timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= shift_q;
			perr_q <= ((^shift_q) == par_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign data_byte    = data_q;
	assign parity_error = perr_q;

	a_emit_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> mode_q == MODE_IDLE && !timer_q && shift_q == '0)
		else $error("frame not closed after byte emitted");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= PARITY_SLOT) else $error("bit index past parity slot");
	a_no_emit_over_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !emit) else $error("pending byte overwritten");
	a_timer_mode: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(timer_q) |-> mode_q == MODE_READ) else $error("timer started outside read");

endmodule

>>> design/fsk_half_period_byte_demodulator.sv
// Top level of the FSK half-period byte demodulator.
// Each accepted word is one event: a comparator capture edge or a bit timer tick. The
// block accepts one event per clock while in_stall is low; the front end measures the
// half-period of an edge in the cycle it is accepted, a two-word queue carries events
// to the frame sequencer, which registers a byte when it retires a frame's tenth tick
// and retires one event per clock unless a finished byte waits on out_stall; only
// then does the queue fill and in_stall rise. Configuration words are taken every
// cycle (cfg_ready is always high); indexes past the register list are ignored.
module fsk_half_period_byte_demodulator import fhpd_pkg::*; #(
	parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      opcode,
	input  logic [CAPTURE_TIME_W-1:0] capture_time,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [BYTE_W-1:0]         data_byte,
	output logic                      parity_error
);

	localparam int HP_W = (CAPTURE_BITS < CAPTURE_TIME_W + 1) ? CAPTURE_BITS
	                      : CAPTURE_TIME_W + 1;
	localparam int Q_W  = HP_W + 1;

	cfg_t            cfg_q;
	logic            push, push_op, q_full, q_valid, pop;
	logic [HP_W-1:0] push_hp;
	logic [Q_W-1:0]  q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counter_modulus <= MODULUS_RESET;
			cfg_q.bit_threshold   <= BIT_THR_RESET;
			cfg_q.start_threshold <= START_THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULUS:   cfg_q.counter_modulus <= cfg_data;
				REG_BIT_THR:   cfg_q.bit_threshold   <= cfg_data;
				REG_START_THR: cfg_q.start_threshold <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fhpd_front #(
		.CAPTURE_BITS(CAPTURE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.capture_time(capture_time),
		.q_full      (q_full),
		.push        (push),
		.push_op     (push_op),
		.push_hp     (push_hp)
	);

	fhpd_queue #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_op, push_hp}),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_valid),
		.pop_data (q_head)
	);

	fhpd_back #(
		.HP_W(HP_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_op        (q_head[Q_W-1]),
		.q_hp        (q_head[HP_W-1:0]),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.parity_error(parity_error)
	);

endmodule
